/* design/tcp_reno_congestion_window_defines.svh */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef TCP_RENO_CONGESTION_WINDOW_DEFINES_SVH
`define TCP_RENO_CONGESTION_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TCPRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCPRC_ASSERT_SAME(lbl, ante, cons, msg)
`define TCPRC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/tcprc_pkg.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - package
// Shared types, command codes, reset values and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcprc_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MSS_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [MSS_W-1:0]  MSS_RESET      = 16'd1460;
  localparam logic [WORD_W-1:0] INIT_THR_RESET = 32'd65535;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK      = 3'd0,
    CMD_LOSS     = 3'd1,
    CMD_FAST_RTX = 3'd2,
    CMD_DUP_ACK  = 3'd3,
    CMD_RCV_ACK  = 3'd4,
    CMD_REINIT   = 3'd5,
    CMD_QUERY    = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSS      = 1'b0,
    CFG_INIT_THR = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CA_COMMIT,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic mul;
    logic div_start;
    logic ca_commit;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
  endfunction

  // max(v, 2*mss); 2*mss never exceeds 17 bits
  function automatic logic [WORD_W-1:0] floor_thr(input logic [WORD_W-1:0] v,
                                                  input logic [MSS_W-1:0]  mss);
    logic [WORD_W-1:0] lo;
    lo = {{(WORD_W-MSS_W-1){1'b0}}, mss, 1'b0};
    return (v > lo) ? v : lo;
  endfunction

endpackage

/* design/tcprc_in_if.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - event channel
// Valid/ready channel carrying one congestion event per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcprc_in_if import tcprc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] acked_bytes;
  logic [WORD_W-1:0] rtx_flight;
  logic              recovery_done;
  logic [WORD_W-1:0] unacked_bytes;
  logic [WORD_W-1:0] seg_bytes;

  modport source (
    output valid, cmd, acked_bytes, rtx_flight, recovery_done,
           unacked_bytes, seg_bytes,
    input  ready
  );

  modport sink (
    input  valid, cmd, acked_bytes, rtx_flight, recovery_done,
           unacked_bytes, seg_bytes,
    output ready
  );
endinterface

/* design/tcprc_out_if.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - result channel
// Valid/ready channel carrying the window state after each event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcprc_out_if import tcprc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] window_bytes;
  logic [WORD_W-1:0] threshold_bytes;
  logic              in_recovery;
  logic              may_send;

  modport source (
    output valid, window_bytes, threshold_bytes, in_recovery, may_send,
    input  ready
  );

  modport sink (
    input  valid, window_bytes, threshold_bytes, in_recovery, may_send,
    output ready
  );
endinterface

/* design/tcprc_div.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcprc_div import tcprc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic [WORD_W-1:0] quotient,
  output logic              done
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (diff[WORD_W]) begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* design/tcprc_dp.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - datapath
// Window, threshold and recovery state, config registers, event arithmetic,
// mss squaring, divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcprc_dp import tcprc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [WORD_W-1:0]    in_acked_bytes,
  input  logic [WORD_W-1:0]    in_rtx_flight,
  input  logic                 in_recovery_done,
  input  logic [WORD_W-1:0]    in_unacked_bytes,
  input  logic [WORD_W-1:0]    in_seg_bytes,
  output logic [WORD_W-1:0]    out_window_bytes,
  output logic [WORD_W-1:0]    out_threshold_bytes,
  output logic                 out_in_recovery,
  output logic                 out_may_send
);

  // config
  logic [MSS_W-1:0]  mss_r;
  logic [WORD_W-1:0] init_thr_r;

  // congestion state
  logic [WORD_W-1:0] window_r, window_nxt;
  logic [WORD_W-1:0] thresh_r, thresh_nxt;
  logic              recov_r, recov_nxt;

  // latched event
  logic [CMD_W-1:0]  op_r;
  logic [WORD_W-1:0] acked_r;
  logic [WORD_W-1:0] flight_r;
  logic              complete_r;
  logic [WORD_W-1:0] inflight_r;
  logic [WORD_W-1:0] seg_r;

  logic              send_ok_r, send_ok_nxt;
  logic [WORD_W-1:0] sq_r;

  // output register
  logic [WORD_W-1:0] win_out_r;
  logic [WORD_W-1:0] thr_out_r;
  logic              recov_out_r;
  logic              send_out_r;

  logic [WORD_W-1:0] mss_w;
  logic [WORD_W-1:0] mss3_w;
  logic [WORD_W-1:0] ss_inc;
  logic [WORD_W-1:0] fr_thr;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] ca_inc;
  logic              div_done;
  logic              slow_start;

  assign mss_w      = {{(WORD_W-MSS_W){1'b0}}, mss_r};
  assign mss3_w     = (mss_w << 1) + mss_w;
  assign ss_inc     = (acked_r < mss_w) ? acked_r : mss_w;
  assign fr_thr     = floor_thr(flight_r >> 1, mss_r);
  assign slow_start = window_r < thresh_r;
  assign ca_inc     = (quo == '0) ? WORD_W'(1) : quo;

  assign stat.need_div = (op_r == CMD_ACK) && (acked_r != '0) && !slow_start
                         && (window_r != '0);
  assign stat.div_done = div_done;

  tcprc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sq_r),
    .divisor  (window_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    window_nxt  = window_r;
    thresh_nxt  = thresh_r;
    recov_nxt   = recov_r;
    send_ok_nxt = send_ok_r;
    if (cmd.exec) begin
      send_ok_nxt = 1'b0;
      unique case (op_r)
        CMD_ACK: begin
          // congestion avoidance with a nonzero window goes to the divider
          if (acked_r != '0) begin
            if (slow_start) begin
              window_nxt = sat_add(window_r, ss_inc);
            end else if (window_r == '0) begin
              window_nxt = WORD_W'(1);
            end
          end
        end
        CMD_LOSS: begin
          thresh_nxt = floor_thr(window_r >> 1, mss_r);
          window_nxt = mss_w;
          recov_nxt  = 1'b0;
        end
        CMD_FAST_RTX: begin
          thresh_nxt = fr_thr;
          window_nxt = sat_add(fr_thr, mss3_w);
          recov_nxt  = 1'b1;
        end
        CMD_DUP_ACK: begin
          if (recov_r) begin
            window_nxt = sat_add(window_r, mss_w);
          end
        end
        CMD_RCV_ACK: begin
          if (recov_r && complete_r) begin
            window_nxt = thresh_r;
            recov_nxt  = 1'b0;
          end
        end
        CMD_REINIT: begin
          window_nxt = mss_w;
          thresh_nxt = floor_thr(init_thr_r, mss_r);
          recov_nxt  = 1'b0;
        end
        CMD_QUERY: begin
          send_ok_nxt = (inflight_r <= window_r) && (seg_r <= window_r - inflight_r);
        end
        default: begin
        end
      endcase
    end else if (cmd.ca_commit) begin
      window_nxt = sat_add(window_r, ca_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r      <= MSS_RESET;
      init_thr_r <= INIT_THR_RESET;
      window_r   <= {{(WORD_W-MSS_W){1'b0}}, MSS_RESET};
      thresh_r   <= floor_thr(INIT_THR_RESET, MSS_RESET);
      recov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MSS:      mss_r      <= cfg_data[MSS_W-1:0];
          CFG_INIT_THR: init_thr_r <= cfg_data;
          default: begin
          end
        endcase
      end
      window_r <= window_nxt;
      thresh_r <= thresh_nxt;
      recov_r  <= recov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    send_ok_r <= send_ok_nxt;
    if (cmd.latch_in) begin
      op_r       <= in_cmd;
      acked_r    <= in_acked_bytes;
      flight_r   <= in_rtx_flight;
      complete_r <= in_recovery_done;
      inflight_r <= in_unacked_bytes;
      seg_r      <= in_seg_bytes;
    end
    // 16x16 product always fits in one word
    if (cmd.mul) begin
      sq_r <= mss_w * mss_w;
    end
    if (cmd.load_out) begin
      win_out_r   <= window_r;
      thr_out_r   <= thresh_r;
      recov_out_r <= recov_r;
      send_out_r  <= send_ok_r;
    end
  end

  assign out_window_bytes    = win_out_r;
  assign out_threshold_bytes = thr_out_r;
  assign out_in_recovery     = recov_out_r;
  assign out_may_send        = send_out_r;

endmodule

/* design/tcprc_ctrl.sv */
// ----------------------------------------------------------------------------
// TCP Reno congestion window - controller
// Sequences one event at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcprc_ctrl import tcprc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:      state_nxt = stat.need_div ? ST_MUL : ST_DONE;
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (stat.div_done) state_nxt = ST_CA_COMMIT;
      ST_CA_COMMIT: state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_EXEC:      cmd.exec      = 1'b1;
      ST_MUL:       cmd.mul       = 1'b1;
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT: begin
      end
      ST_CA_COMMIT: cmd.ca_commit = 1'b1;
      ST_DONE:      cmd.load_out  = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/tcp_reno_congestion_window.sv */
// TCP Reno congestion window. Each transaction on the event channel is one
// event (ack, timeout loss, fast retransmit, duplicate ack, recovery ack,
// reinitialize, send query) and yields exactly one result carrying the
// window, threshold and recovery flag after the event, plus the send answer
// for a query. Events run one at a time: most pass EXEC and DONE; an ack
// in congestion avoidance adds MUL, DIV_START, DIV_WAIT (radix-2 divide of
// mss*mss by window) and CA_COMMIT. A finished result sits in an output
// register, so the next event is taken while it waits. Config registers
// (index 0 mss, index 1 initial threshold) are to be written only while
// idle by the user, unenforced; they reach window and threshold at reinit.
`timescale 1ns / 1ps
`include "tcp_reno_congestion_window_defines.svh"

// ----------------------------------------------------------------------------
// TCP Reno congestion window - top level
// Controller plus datapath behind valid/ready event and result channels.
// ----------------------------------------------------------------------------
module tcp_reno_congestion_window import tcprc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tcprc_in_if.sink             in_ch,
  tcprc_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  tcprc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  tcprc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (ctrl_cmd),
    .stat                 (dp_stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_cmd               (in_ch.cmd),
    .in_acked_bytes       (in_ch.acked_bytes),
    .in_rtx_flight        (in_ch.rtx_flight),
    .in_recovery_done     (in_ch.recovery_done),
    .in_unacked_bytes     (in_ch.unacked_bytes),
    .in_seg_bytes         (in_ch.seg_bytes),
    .out_window_bytes     (out_ch.window_bytes),
    .out_threshold_bytes  (out_ch.threshold_bytes),
    .out_in_recovery      (out_ch.in_recovery),
    .out_may_send         (out_ch.may_send)
  );

  `TCPRC_ASSERT_NEXT(a_one_event, in_ch.valid && in_ch.ready, !in_ch.ready, "event accepted while busy")
  `TCPRC_ASSERT_SAME(a_no_overwrite, ctrl_cmd.load_out, !out_ch.valid || out_ch.ready, "result overwritten")
  `TCPRC_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(ctrl_cmd), "multiple datapath commands")

endmodule

/* tb/tb_tcp_reno_congestion_window.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// TCP Reno congestion window - testbench
// Sends congestion events through randomly stalled valid/ready channels,
// predicts window, threshold, recovery flag and send answer for every event
// with a behavioral model, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_tcp_reno_congestion_window;
  import tcprc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 960;
  localparam int IDLE_PCT       = 28;

  typedef struct packed {
    logic [WORD_W-1:0] window_bytes;
    logic [WORD_W-1:0] threshold_bytes;
    logic              in_recovery;
    logic              may_send;
  } cwnd_report_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [WORD_W-1:0] cfg_data;

  tcprc_in_if  ev_ch ();
  tcprc_out_if rpt_ch ();

  tcp_reno_congestion_window u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (ev_ch.sink),
    .out_ch   (rpt_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // behavioral copy of the window state and registers
  logic [MSS_W-1:0]  mss;
  logic [WORD_W-1:0] init_thr;
  logic [WORD_W-1:0] cwnd;
  logic [WORD_W-1:0] ssthresh;
  logic              recovering;

  cwnd_report_t report_q[$];
  int           mismatches = 0;
  int           events_sent;
  bit           idle_on;

  always #2 clk = ~clk;

  function automatic logic [WORD_W-1:0] add_clamped(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
    return (a > ~b) ? '1 : a + b;
  endfunction

  function automatic logic [WORD_W-1:0] two_mss_floor(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] lo;
    lo = WORD_W'(mss) << 1;
    return (v > lo) ? v : lo;
  endfunction

  function automatic void restart_window();
    cwnd       = WORD_W'(mss);
    ssthresh   = two_mss_floor(init_thr);
    recovering = 1'b0;
  endfunction

  // applies one event to the window state and returns the report it yields
  function automatic cwnd_report_t advance_cwnd(input logic [CMD_W-1:0]  code,
                                                input logic [WORD_W-1:0] acked,
                                                input logic [WORD_W-1:0] flight,
                                                input logic              complete,
                                                input logic [WORD_W-1:0] inflight,
                                                input logic [WORD_W-1:0] seg);
    logic [63:0]       mss_sq;
    logic [63:0]       quo;
    logic [WORD_W-1:0] step;
    logic              send_ok;
    cwnd_report_t      r;
    send_ok = 1'b0;
    case (code)
      CMD_ACK: begin
        if (acked != '0) begin
          if (cwnd < ssthresh) begin
            step = (acked < WORD_W'(mss)) ? acked : WORD_W'(mss);
          end else begin
            mss_sq = 64'(mss) * 64'(mss);
            quo    = (cwnd != '0) ? mss_sq / 64'(cwnd) : 64'd0;
            step   = (quo == 64'd0) ? WORD_W'(1) : quo[WORD_W-1:0];
          end
          cwnd = add_clamped(cwnd, step);
        end
      end
      CMD_LOSS: begin
        ssthresh   = two_mss_floor(cwnd >> 1);
        cwnd       = WORD_W'(mss);
        recovering = 1'b0;
      end
      CMD_FAST_RTX: begin
        ssthresh   = two_mss_floor(flight >> 1);
        cwnd       = add_clamped(ssthresh, WORD_W'(mss) * 3);
        recovering = 1'b1;
      end
      CMD_DUP_ACK: begin
        if (recovering) cwnd = add_clamped(cwnd, WORD_W'(mss));
      end
      CMD_RCV_ACK: begin
        if (recovering && complete) begin
          cwnd       = ssthresh;
          recovering = 1'b0;
        end
      end
      CMD_REINIT: restart_window();
      CMD_QUERY: send_ok = (inflight <= cwnd) && (seg <= cwnd - inflight);
      default: ;
    endcase
    r.window_bytes    = cwnd;
    r.threshold_bytes = ssthresh;
    r.in_recovery     = recovering;
    r.may_send        = send_ok;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_event(input logic [CMD_W-1:0]  code,
                            input logic [WORD_W-1:0] acked,
                            input logic [WORD_W-1:0] flight,
                            input logic              complete,
                            input logic [WORD_W-1:0] inflight,
                            input logic [WORD_W-1:0] seg);
    int gap;
    gap = (idle_on && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      ev_ch.valid <= 1'b0;
    end
    @(negedge clk);
    ev_ch.valid         <= 1'b1;
    ev_ch.cmd           <= code;
    ev_ch.acked_bytes   <= acked;
    ev_ch.rtx_flight    <= flight;
    ev_ch.recovery_done <= complete;
    ev_ch.unacked_bytes <= inflight;
    ev_ch.seg_bytes     <= seg;
    do @(posedge clk); while (!ev_ch.ready);
    report_q.push_back(advance_cwnd(code, acked, flight, complete, inflight, seg));
    if (code != CMD_UNUSED) events_sent++;
  endtask

  // arg lands in the field the command uses; flag drives recovery_done, the rest is filler
  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [WORD_W-1:0] arg,
                          input logic flag);
    send_event(code, (code == CMD_ACK) ? arg : $urandom(),
               (code == CMD_FAST_RTX) ? arg : $urandom(), flag, $urandom(), $urandom());
  endtask

  task automatic send_query(input logic [WORD_W-1:0] inflight, input logic [WORD_W-1:0] seg);
    send_event(CMD_QUERY, $urandom(), $urandom(), 1'($urandom_range(1)), inflight, seg);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    ev_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MSS) mss = data[MSS_W-1:0];
    else init_thr = data;
  endtask

  // a reinitialize restarts window and threshold from the new register values
  task automatic set_regs(input logic [WORD_W-1:0] mss_word, input logic [WORD_W-1:0] thr);
    wait_drained();
    write_reg(CFG_MSS, mss_word);
    write_reg(CFG_INIT_THR, thr);
    send_cmd(CMD_REINIT, $urandom(), 1'($urandom_range(1)));
  endtask

  function automatic logic [WORD_W-1:0] pick_acked();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return $urandom();
      3:       return WORD_W'(mss);
      default: return $urandom_range(int'(mss) * 2 + 1, 1);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_flight();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return cwnd;
      2:       return $urandom_range(cwnd);
      default: return $urandom_range(int'(mss) * 16);
    endcase
  endfunction

  task automatic random_query();
    logic [WORD_W-1:0] inflight;
    logic [WORD_W-1:0] room;
    logic [WORD_W-1:0] seg;
    case ($urandom_range(3))
      0:       inflight = $urandom();
      1:       inflight = cwnd;
      default: inflight = $urandom_range(cwnd);
    endcase
    room = (inflight <= cwnd) ? cwnd - inflight : '0;
    case ($urandom_range(3))
      0:       seg = room;
      1:       seg = room + 1;
      2:       seg = $urandom();
      default: seg = $urandom_range(room);
    endcase
    send_query(inflight, seg);
  endtask

  task automatic random_acks(input int n);
    repeat (n) begin
      if ($urandom_range(4) == 0) random_query();
      else send_cmd(CMD_ACK, pick_acked(), 1'($urandom_range(1)));
    end
  endtask

  // mostly protocol-shaped sequences, some pure noise
  task automatic run_episode();
    case ($urandom_range(9))
      0, 1, 2: random_acks($urandom_range(3, 20));
      3, 4, 5: begin
        send_cmd(CMD_FAST_RTX, pick_flight(), 1'($urandom_range(1)));
        repeat ($urandom_range(8)) begin
          if ($urandom_range(3) == 0) random_query();
          else send_cmd(CMD_DUP_ACK, $urandom(), 1'($urandom_range(1)));
        end
        if ($urandom_range(2) == 0) send_cmd(CMD_RCV_ACK, $urandom(), 1'b0);
        if ($urandom_range(4) == 0) send_cmd(CMD_LOSS, $urandom(), 1'($urandom_range(1)));
        else send_cmd(CMD_RCV_ACK, $urandom(), 1'b1);
        random_acks($urandom_range(1, 6));
      end
      6: begin
        send_cmd(CMD_LOSS, $urandom(), 1'($urandom_range(1)));
        random_acks($urandom_range(2, 10));
      end
      7: begin
        send_cmd(CMD_REINIT, $urandom(), 1'($urandom_range(1)));
        random_query();
      end
      default: begin
        repeat ($urandom_range(2, 8))
          send_event(CMD_W'($urandom_range(7)), $urandom(), $urandom(),
                     1'($urandom_range(1)), $urandom(), $urandom());
      end
    endcase
  endtask

  task automatic test_reset_values();
    send_query('0, '0);
    send_event(CMD_UNUSED, '1, '1, 1'b1, '1, '1);
  endtask

  task automatic test_slow_start();
    send_cmd(CMD_ACK, '0, 1'b0);
    send_cmd(CMD_ACK, 32'd1, 1'b1);
    send_cmd(CMD_ACK, '1, 1'b0);
    send_cmd(CMD_ACK, WORD_W'(mss) - 1, 1'b0);
  endtask

  task automatic test_congestion_avoidance();
    send_cmd(CMD_LOSS, '0, 1'b0);
    send_cmd(CMD_ACK, WORD_W'(mss), 1'b0);
    send_cmd(CMD_ACK, 32'd7, 1'b0);
    send_cmd(CMD_ACK, '1, 1'b1);
  endtask

  task automatic test_fast_recovery();
    // duplicate and recovery acks are ignored outside recovery
    send_cmd(CMD_DUP_ACK, '0, 1'b0);
    send_cmd(CMD_RCV_ACK, '0, 1'b1);
    send_cmd(CMD_FAST_RTX, '0, 1'b0);
    send_cmd(CMD_DUP_ACK, '0, 1'b0);
    send_cmd(CMD_RCV_ACK, '0, 1'b0);
    send_cmd(CMD_RCV_ACK, '0, 1'b1);
    send_cmd(CMD_FAST_RTX, '1, 1'b1);
    send_cmd(CMD_DUP_ACK, '0, 1'b1);
    send_cmd(CMD_LOSS, '0, 1'b0);
    send_cmd(CMD_REINIT, '0, 1'b0);
  endtask

  task automatic test_send_query();
    send_query(cwnd + 1, '0);
    send_query(cwnd, '0);
    send_query('0, cwnd);
    send_query('0, cwnd + 1);
    send_query('1, '1);
    send_query(32'd100, cwnd - 100);
  endtask

  task automatic test_register_settings();
    // zero mss: window and floors collapse, zero window in avoidance grows by one
    set_regs(32'hFFFF_0000, '0);
    send_cmd(CMD_ACK, 32'd5, 1'b0);
    send_cmd(CMD_ACK, '1, 1'b0);
    send_cmd(CMD_FAST_RTX, 32'd10, 1'b0);
    send_cmd(CMD_DUP_ACK, '0, 1'b0);
    send_cmd(CMD_LOSS, '0, 1'b0);
    send_query('0, '0);
    set_regs(32'h0000_FFFF, '1);
    random_acks(4);
    send_cmd(CMD_FAST_RTX, '1, 1'b0);
    send_cmd(CMD_DUP_ACK, '0, 1'b0);
    send_cmd(CMD_RCV_ACK, '0, 1'b1);
    send_cmd(CMD_ACK, '1, 1'b0);
    set_regs(32'd1, '0);
    random_acks(6);
    set_regs({16'($urandom_range(16'hFFFF)), MSS_RESET}, INIT_THR_RESET);
  endtask

  task automatic test_random_traffic();
    logic [WORD_W-1:0] mss_word [6];
    logic [WORD_W-1:0] thr_word [6];
    int                target;
    int                per_phase;
    mss_word  = '{32'd1460, 32'd536, 32'hFFFF_FFFF, 32'd1, $urandom(), 32'd9000};
    thr_word  = '{32'd65535, 32'd0, 32'hFFFF_FFFF, 32'd200000, $urandom(),
                  $urandom_range(100000)};
    per_phase = RANDOM_ITEMS / 6;
    for (int p = 0; p < 6; p++) begin
      set_regs(mss_word[p], thr_word[p]);
      idle_on = (p != 2);
      target  = events_sent + per_phase;
      while (events_sent < target - per_phase / 2) run_episode();
      // hold the sender until the pipeline is empty
      wait_drained();
      while (events_sent < target) run_episode();
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) rpt_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : result_check
    cwnd_report_t want;
    if (rst_n && rpt_ch.valid && rpt_ch.ready) begin
      if (report_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none actual window %0d",
                 $time, rpt_ch.window_bytes);
      end else begin
        want = report_q.pop_front();
        check_field("window_bytes", want.window_bytes, rpt_ch.window_bytes);
        check_field("threshold_bytes", want.threshold_bytes, rpt_ch.threshold_bytes);
        check_field("in_recovery", WORD_W'(want.in_recovery), WORD_W'(rpt_ch.in_recovery));
        check_field("may_send", WORD_W'(want.may_send), WORD_W'(rpt_ch.may_send));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((ev_ch.valid && ev_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_tcp_reno_congestion_window NOT OK");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MSS;
    cfg_data            = '0;
    ev_ch.valid         = 1'b0;
    ev_ch.cmd           = CMD_ACK;
    ev_ch.acked_bytes   = '0;
    ev_ch.rtx_flight    = '0;
    ev_ch.recovery_done = 1'b0;
    ev_ch.unacked_bytes = '0;
    ev_ch.seg_bytes     = '0;
    events_sent         = 0;
    idle_on             = 1'b1;
    mss                 = MSS_RESET;
    init_thr            = INIT_THR_RESET;
    restart_window();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_slow_start();
    test_congestion_avoidance();
    test_fast_recovery();
    test_send_query();
    test_register_settings();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("tb_tcp_reno_congestion_window OK");
    end else begin
      $display("tb_tcp_reno_congestion_window NOT OK");
    end
    $finish;
  end

endmodule
